// File: design/byte_ring_fifo_top_defines.svh
// Assertion macros used by the byte ring FIFO top level.
`ifndef BYTE_RING_FIFO_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/brf_pkg.sv
// Types and request codes for the byte ring FIFO.
`timescale 1ns / 1ps
package brf_pkg;

    localparam int FIELD_W = 10;

    localparam logic [2:0] REQ_ENQUEUE    = 3'd0;
    localparam logic [2:0] REQ_DEQUEUE    = 3'd1;
    localparam logic [2:0] REQ_PEEK       = 3'd2;
    localparam logic [2:0] REQ_SKIP_FRONT = 3'd3;
    localparam logic [2:0] REQ_SKIP_REAR  = 3'd4;
    localparam logic [2:0] REQ_CLEAR      = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         data_byte;
        logic               run_first;
        logic [FIELD_W-1:0] length;
    } req_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               last;
        logic               status;
        logic [FIELD_W-1:0] moved_count;
        logic [FIELD_W-1:0] used_size;
        logic [FIELD_W-1:0] free_size;
        logic [FIELD_W-1:0] contig_enqueue;
        logic [FIELD_W-1:0] contig_dequeue;
    } rsp_t;

endpackage

// File: design/byte_ring_fifo_top.sv
// Byte ring FIFO top level: ring store, head/tail pointers and read burst sequencer.
//
//  channel   | handshake       | payload          | direction
//  ----------+-----------------+------------------+----------
//  request   | start / busy    | item   (req_t)   | in
//  result    | done strobe     | result (rsp_t)   | out
//
// Single-result requests: the result is strobed in the cycle after acceptance, and a new
// request may be accepted in that same cycle.
// A dequeue or peek of N bytes holds busy while it issues N ring reads, one per cycle through
// the single read port; each result follows in the cycle after its read, one per cycle.
// Reset clears the pointers, the open-run flag and the sequencer; the ring holds garbage.
// The receiver cannot stall: every result is shown for exactly one cycle.
`timescale 1ns / 1ps
module byte_ring_fifo_top #(
    parameter int CAPACITY       = 1023,
    parameter int MAX_READ_BURST = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  brf_pkg::req_t item,
    output logic          done,
    output brf_pkg::rsp_t result
);

    `include "byte_ring_fifo_top_defines.svh"

    localparam int SLOTS = CAPACITY + 1;
    localparam int PTR_W = $clog2(SLOTS);
    localparam int W     = (PTR_W + 1 > brf_pkg::FIELD_W) ? PTR_W + 1 : brf_pkg::FIELD_W;
    localparam int RW    = $clog2(MAX_READ_BURST + 1);

    localparam logic [W-1:0] SLOTS_W = W'(SLOTS);
    localparam logic [W-1:0] CAP_W   = W'(CAPACITY);
    localparam logic [W-1:0] BURST_W = W'(MAX_READ_BURST);

    // Step a ring pointer forward by n < SLOTS, wrapping once.
    function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                                   input logic [W-1:0] n);
        logic [W-1:0] s;
        s = W'(p) + n;
        if (s >= SLOTS_W)
        begin
            s = s - SLOTS_W;
        end
        return s[PTR_W-1:0];
    endfunction

    // Ring store
    logic [7:0] mem [0:CAPACITY];
    logic [7:0] rd_data_reg;
    logic       mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic       rd_en;

    // Control and pointer state
    brf_pkg::state_t state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             run_reg, run_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RW-1:0]    rem_reg, rem_next;

    // Result register
    logic                        done_reg, done_next;
    logic                        res_last_reg, res_last_next;
    logic                        res_status_reg, res_status_next;
    logic [brf_pkg::FIELD_W-1:0] res_moved_reg, res_moved_next;
    logic                        res_mem_reg, res_mem_next;

    logic         accept;
    logic         burst_go;
    logic [W-1:0] head_w, tail_w, len_w;
    logic [W-1:0] used_w, free_w, ce_w, cd_w;

    assign accept = start && !busy;
    assign head_w = W'(head_reg);
    assign tail_w = W'(tail_reg);
    assign len_w  = W'(item.length);

    // Sizes of the current state; during a result cycle this is already the post-step state.
    always_comb
    begin
        used_w = (tail_w - head_w) + ((head_reg > tail_reg) ? SLOTS_W : '0);
        free_w = CAP_W - used_w;
        if (tail_reg < head_reg)
        begin
            ce_w = head_w - W'(1) - tail_w;
            cd_w = CAP_W - head_w;
        end
        else
        begin
            ce_w = CAP_W - tail_w;
            cd_w = tail_w - head_w;
        end
    end

    assign burst_go = accept
                      && (item.req_type inside {brf_pkg::REQ_DEQUEUE, brf_pkg::REQ_PEEK})
                      && (len_w <= BURST_W) && (len_w <= used_w) && (len_w != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brf_pkg::ST_IDLE:
            begin
                if (burst_go)
                begin
                    state_next = brf_pkg::ST_READ;
                end
            end
            brf_pkg::ST_READ:
            begin
                if (rem_reg == RW'(1))
                begin
                    state_next = brf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        case (state_reg)
            brf_pkg::ST_READ:
            begin
                busy  = 1'b1;
                rd_en = 1'b1;
            end
            default:
            begin
                busy  = 1'b0;
                rd_en = 1'b0;
            end
        endcase
    end

    // Request decode and pointer updates
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        run_next        = run_reg;
        rd_ptr_next     = rd_ptr_reg;
        rem_next        = rem_reg;
        mem_we          = 1'b0;
        mem_waddr       = ring_adv(tail_reg, W'(1));
        done_next       = 1'b0;
        res_last_next   = res_last_reg;
        res_status_next = res_status_reg;
        res_moved_next  = res_moved_reg;
        res_mem_next    = res_mem_reg;

        if (rd_en)
        begin
            // Issue one read per cycle; its beat goes out next cycle.
            rd_ptr_next     = ring_adv(rd_ptr_reg, W'(1));
            rem_next        = rem_reg - RW'(1);
            done_next       = 1'b1;
            res_last_next   = (rem_reg == RW'(1));
            res_status_next = 1'b0;
            res_mem_next    = 1'b1;
        end
        else if (accept)
        begin
            done_next       = 1'b1;
            res_last_next   = 1'b1;
            res_status_next = 1'b1;
            res_moved_next  = '0;
            res_mem_next    = 1'b0;
            if (item.req_type != brf_pkg::REQ_ENQUEUE)
            begin
                run_next = 1'b0;
            end
            case (item.req_type)
                brf_pkg::REQ_ENQUEUE:
                begin
                    if (item.run_first)
                    begin
                        run_next = 1'b0;
                        if (len_w <= free_w)
                        begin
                            res_status_next = 1'b0;
                            if (len_w != '0)
                            begin
                                mem_we         = 1'b1;
                                tail_next      = mem_waddr;
                                run_next       = 1'b1;
                                res_moved_next = item.length;
                            end
                        end
                    end
                    else if (!run_reg || (free_w == '0))
                    begin
                        run_next = 1'b0;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        tail_next       = mem_waddr;
                        res_status_next = 1'b0;
                        res_moved_next  = brf_pkg::FIELD_W'(1);
                    end
                end
                brf_pkg::REQ_DEQUEUE, brf_pkg::REQ_PEEK:
                begin
                    if ((len_w <= BURST_W) && (len_w <= used_w))
                    begin
                        res_status_next = 1'b0;
                        if (len_w != '0)
                        begin
                            // Burst: results come from the read sequencer.
                            done_next      = 1'b0;
                            res_moved_next = item.length;
                            rd_ptr_next    = ring_adv(head_reg, W'(1));
                            rem_next       = RW'(item.length);
                            if (item.req_type == brf_pkg::REQ_DEQUEUE)
                            begin
                                head_next = ring_adv(head_reg, len_w);
                            end
                        end
                    end
                end
                brf_pkg::REQ_SKIP_FRONT:
                begin
                    if (len_w <= used_w)
                    begin
                        head_next       = ring_adv(head_reg, len_w);
                        res_status_next = 1'b0;
                        res_moved_next  = item.length;
                    end
                end
                brf_pkg::REQ_SKIP_REAR:
                begin
                    if (len_w <= free_w)
                    begin
                        tail_next       = ring_adv(tail_reg, len_w);
                        res_status_next = 1'b0;
                        res_moved_next  = item.length;
                    end
                end
                brf_pkg::REQ_CLEAR:
                begin
                    head_next       = tail_reg;
                    res_status_next = 1'b0;
                    res_moved_next  = used_w[brf_pkg::FIELD_W-1:0];
                end
                default:
                begin
                    res_status_next = 1'b1;
                end
            endcase
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= item.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brf_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            run_reg   <= 1'b0;
            rem_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            run_reg   <= run_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        res_last_reg   <= res_last_next;
        res_status_reg <= res_status_next;
        res_moved_reg  <= res_moved_next;
        res_mem_reg    <= res_mem_next;
    end

    assign done = done_reg;

    always_comb
    begin
        result.out_byte       = res_mem_reg ? rd_data_reg : 8'd0;
        result.last           = res_last_reg;
        result.status         = res_status_reg;
        result.moved_count    = res_moved_reg;
        result.used_size      = used_w[brf_pkg::FIELD_W-1:0];
        result.free_size      = free_w[brf_pkg::FIELD_W-1:0];
        result.contig_enqueue = ce_w[brf_pkg::FIELD_W-1:0];
        result.contig_dequeue = cd_w[brf_pkg::FIELD_W-1:0];
    end

    `BRF_ASSERT_NOW(a_ptr_range, 1'b1,
        (W'(head_reg) <= CAP_W) && (W'(tail_reg) <= CAP_W), "ring pointer past last slot")
    `BRF_ASSERT_NOW(a_rem_live, state_reg == brf_pkg::ST_READ, rem_reg != '0,
        "read sequencer active with no bytes left")
    `BRF_ASSERT_NEXT(a_read_beat, state_reg == brf_pkg::ST_READ, done_reg,
        "read issued without a result beat")
    `BRF_ASSERT_NOW(a_midburst, done_reg && !res_last_reg,
        state_reg == brf_pkg::ST_READ, "non-final beat outside a read burst")
    `BRF_ASSERT_NEXT(a_single_result, accept && !burst_go, done_reg && res_last_reg,
        "single-result request gave no final beat")

endmodule
